// ----- rtl/core/pbim_pkg.sv -----
// Package for the pairwise box intersection matrix block.
// Holds the payload structs, the controller command and status types and the sizing constants.
// No dependencies; every other file of the block imports it.
package pbim_pkg;

  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned IdxW     = $clog2(MaxBoxes);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned AreaW    = 32;

  // One stored box, 64 bits.
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } coord_box_t;

  typedef struct packed {
    logic              first_box;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } box_in_t;

  typedef struct packed {
    logic [IdxW-1:0]  row_index;
    logic [IdxW-1:0]  col_index;
    logic [AreaW-1:0] area;
    logic             overflow;
    logic             last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StOvf,
    StDrain
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic            issue;
    logic [IdxW-1:0] col;
    logic            diag;
    logic            ovf;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic adv;
  } dp_status_t;

endpackage

// ----- rtl/core/pairwise_box_intersection_matrix.sv -----
// Pairwise box intersection matrix: box j yields j pair areas, then the diagonal.
// The first result of a box passes through the store read, overlap and multiply registers.
// One stored box is compared per cycle while the output is not stalled, set by the single
// read port of the box store; the next box is accepted only once the pipeline has drained.
// Reset: asynchronous, active low; clears the box count and the pipeline valids.
module pairwise_box_intersection_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbim_pkg::box_in_t in_box_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbim_pkg::result_t out_res_o
);
  import pbim_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pbim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_first_i (in_box_i.first_box),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  pbim_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (in_box_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res_o),
    .status_o    (status)
  );

endmodule

// ----- rtl/core/pbim_ctrl.sv -----
// Controller state machine of the pairwise box intersection matrix block.
// Tracks the box count, issues one column per cycle to the datapath while it advances. Uses pbim_pkg.
module pbim_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_first_i,
  input  pbim_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output pbim_pkg::dp_cmd_t   cmd_o
);
  import pbim_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] row_q, row_d;
  logic [IdxW-1:0] col_q, col_d;

  logic [CntW-1:0] j_eff;
  logic            full;
  logic            accept;

  // A first box restarts the set before the capacity check.
  assign j_eff  = in_first_i ? '0 : count_q;
  assign full   = (j_eff == CntW'(MaxBoxes));
  assign accept = (state_q == StIdle) && in_valid_i;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    row_d   = row_q;
    col_d   = col_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (full) begin
            state_d = StOvf;
          end else begin
            state_d = StRun;
            count_d = j_eff + CntW'(1);
            row_d   = j_eff[IdxW-1:0];
            col_d   = '0;
          end
        end
      end
      StRun: begin
        if (status_i.adv) begin
          if (col_q == row_q) begin
            state_d = StDrain;
          end else begin
            col_d = col_q + IdxW'(1);
          end
        end
      end
      StOvf: begin
        if (status_i.adv) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.wr_addr = j_eff[IdxW-1:0];
    cmd_o.col     = col_q;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.wr_en = accept && !full;
      end
      StRun: begin
        cmd_o.issue = status_i.adv;
        cmd_o.diag  = (col_q == row_q);
      end
      StOvf: begin
        cmd_o.issue = status_i.adv;
        cmd_o.ovf   = 1'b1;
      end
      StDrain: begin
        in_ready_o = 1'b0;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBoxes))
    else $error("Box count exceeds capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.busy)
    else $error("Input ready while the datapath still holds work.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (col_q <= row_q))
    else $error("Column ran past the diagonal.");

endmodule

// ----- rtl/core/pbim_dp.sv -----
// Datapath of the pairwise box intersection matrix block.
// Box store, read stage, overlap stage and multiply/output register. Uses pbim_pkg.
module pbim_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbim_pkg::box_in_t    box_i,
  input  pbim_pkg::dp_cmd_t    cmd_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output pbim_pkg::result_t    res_o,
  output pbim_pkg::dp_status_t status_o
);
  import pbim_pkg::*;

  coord_box_t      mem_q [MaxBoxes];
  coord_box_t      cur_q;
  logic [IdxW-1:0] row_q;

  // Stage 1: store read.
  logic            v1_q;
  coord_box_t      rd_q;
  logic [IdxW-1:0] col1_q;
  logic            diag1_q, ovf1_q;

  // Stage 2: overlap lengths.
  logic              v2_q;
  logic [CoordW-1:0] dx_q, dy_q;
  logic              zero_q;
  logic [IdxW-1:0]   col2_q;
  logic              diag2_q, ovf2_q;

  logic              out_valid_q;
  result_t           res_q;

  logic              adv;
  logic [CoordW:0]   lo_x, hi_x, lo_y, hi_y;
  logic [CoordW:0]   ea_x, eb_x, ea_y, eb_y;
  logic [CoordW-1:0] dx, dy;
  logic              zero;
  logic [AreaW-1:0]  prod;

  assign adv = !out_valid_q || out_ready_i;

  // Edges at 17 bits so that left plus width never wraps.
  always_comb begin
    ea_x = {1'b0, rd_q.left}  + {1'b0, rd_q.width};
    eb_x = {1'b0, cur_q.left} + {1'b0, cur_q.width};
    ea_y = {1'b0, rd_q.top}   + {1'b0, rd_q.height};
    eb_y = {1'b0, cur_q.top}  + {1'b0, cur_q.height};
    lo_x = (rd_q.left > cur_q.left) ? {1'b0, rd_q.left} : {1'b0, cur_q.left};
    lo_y = (rd_q.top > cur_q.top) ? {1'b0, rd_q.top} : {1'b0, cur_q.top};
    hi_x = (ea_x < eb_x) ? ea_x : eb_x;
    hi_y = (ea_y < eb_y) ? ea_y : eb_y;
    // The overlap never exceeds either width, so it fits 16 bits.
    dx   = (hi_x > lo_x) ? CoordW'(hi_x - lo_x) : '0;
    dy   = (hi_y > lo_y) ? CoordW'(hi_y - lo_y) : '0;
    zero = (rd_q.width == '0) || (rd_q.height == '0) ||
           (cur_q.width == '0) || (cur_q.height == '0);
  end

  assign prod = AreaW'(dx_q) * AreaW'(dy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= {box_i.left, box_i.top, box_i.width, box_i.height};
      cur_q                <= {box_i.left, box_i.top, box_i.width, box_i.height};
      row_q                <= cmd_i.wr_addr;
    end
    if (adv) begin
      rd_q    <= mem_q[cmd_i.col];
      col1_q  <= cmd_i.col;
      diag1_q <= cmd_i.diag;
      ovf1_q  <= cmd_i.ovf;
      dx_q    <= dx;
      dy_q    <= dy;
      zero_q  <= zero;
      col2_q  <= col1_q;
      diag2_q <= diag1_q;
      ovf2_q  <= ovf1_q;
      res_q.overflow    <= ovf2_q;
      res_q.last_of_run <= diag2_q || ovf2_q;
      res_q.row_index   <= ovf2_q ? '0 : row_q;
      res_q.col_index   <= ovf2_q ? '0 : col2_q;
      if (ovf2_q || (zero_q && !diag2_q)) begin
        res_q.area <= '0;
      end else if (diag2_q) begin
        res_q.area <= AreaW'(1);
      end else begin
        res_q.area <= prod;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign res_o         = res_q;
  assign status_o.adv  = adv;
  assign status_o.busy = v1_q || v2_q || out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.overflow) |-> (res_o.last_of_run && res_o.area == '0))
    else $error("Overflow transaction carries an area or is not last.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !res_o.overflow && res_o.col_index == res_o.row_index)
      |-> (res_o.last_of_run && res_o.area == AreaW'(1)))
    else $error("Diagonal transaction is malformed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !res_o.last_of_run) |-> (res_o.col_index < res_o.row_index))
    else $error("Pair transaction outside the lower triangle.");

endmodule
